### rtl/yab_pkg.sv
// ----------------------------------------------------------------------------
// yab_pkg
// Shared types, constants and the fixed-point sigmoid for the anchor box decoder.
// ----------------------------------------------------------------------------
package yab_pkg;

    localparam int MAX_CLASSES_DEF = 128;
    localparam int GRID_ROWS_DEF   = 128;
    localparam int GRID_COLS_DEF   = 128;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_OBJ_THR     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_EN   = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_LO    = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_HI    = 8'd7;

    localparam logic [16:0] OBJ_THR_RST     = 17'd16384;
    localparam logic [16:0] SCORE_THR_RST   = 17'd19661;
    localparam logic [15:0] SCALE_RST       = 16'd4096;
    localparam logic [7:0]  CLASS_COUNT_RST = 8'd80;

    localparam logic [1:0] LEVEL_MAX  = 2'd2;
    localparam logic [1:0] ANCHOR_MAX = 2'd2;

    // log2 of the smallest stride plus the Q.16 fraction
    localparam int STRIDE_SHIFT_BASE = 19;

    localparam logic [15:0] SIG_TABLE [0:16] = '{
        16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
        16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
        16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
    };

    localparam logic [8:0] ANCHOR_W [0:2][0:2] = '{
        '{9'd12,  9'd19,  9'd40},
        '{9'd36,  9'd76,  9'd72},
        '{9'd142, 9'd192, 9'd459}
    };

    localparam logic [8:0] ANCHOR_H [0:2][0:2] = '{
        '{9'd16,  9'd36,  9'd28},
        '{9'd75,  9'd55,  9'd146},
        '{9'd110, 9'd243, 9'd401}
    };

    typedef struct packed {
        logic [16:0] obj_thr;
        logic [16:0] score_thr;
        logic [15:0] scale_x;
        logic [15:0] scale_y;
        logic [7:0]  class_count;
        logic        filter_en;
        logic [63:0] allow_lo;
        logic [63:0] allow_hi;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  level;
        logic [1:0]  asel;
        logic [6:0]  cell_x;
        logic [6:0]  cell_y;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        logic [15:0] raw_w;
        logic [15:0] raw_h;
        logic [6:0]  cls;
        logic [16:0] score;
    } t_job;

    // Q8.8 logit to Q0.16 probability, table plus linear interpolation
    function automatic logic [16:0] sig_q16(input logic [15:0] raw);
        logic [16:0] mag;
        logic [15:0] base;
        logic [15:0] nxt;
        logic [12:0] diff;
        logic [19:0] prod;
        logic [15:0] y;
        mag  = raw[15] ? (17'd0 - {raw[15], raw}) : {1'b0, raw};
        base = SIG_TABLE[{1'b0, mag[10:7]}];
        nxt  = SIG_TABLE[5'({1'b0, mag[10:7]}) + 5'd1];
        diff = 13'(nxt - base);
        prod = 20'(diff) * 20'(mag[6:0]);
        if (|mag[16:11]) begin
            y = SIG_TABLE[16];
        end else begin
            y = base + 16'(prod >> 7);
        end
        return raw[15] ? (17'd65536 - {1'b0, y}) : {1'b0, y};
    endfunction

endpackage

### rtl/yab_ifs.sv
// ----------------------------------------------------------------------------
// yab channel interfaces
// Candidate, box and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface yab_cand_if;
    logic        valid;
    logic        ready;
    logic [1:0]  scale_level;
    logic [1:0]  anchor_sel;
    logic [6:0]  cell_x;
    logic [6:0]  cell_y;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [15:0] raw_w;
    logic [15:0] raw_h;
    logic [15:0] raw_obj;
    logic [6:0]  class_index;
    logic [15:0] raw_class;

    modport source (
        output valid, scale_level, anchor_sel, cell_x, cell_y, raw_x, raw_y,
               raw_w, raw_h, raw_obj, class_index, raw_class,
        input  ready
    );
    modport sink (
        input  valid, scale_level, anchor_sel, cell_x, cell_y, raw_x, raw_y,
               raw_w, raw_h, raw_obj, class_index, raw_class,
        output ready
    );
endinterface

interface yab_box_if;
    logic        valid;
    logic        ready;
    logic [6:0]  out_class;
    logic [16:0] out_score;
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [14:0] box_width;
    logic [14:0] box_height;

    modport source (
        output valid, out_class, out_score, box_left, box_top, box_width, box_height,
        input  ready
    );
    modport sink (
        input  valid, out_class, out_score, box_left, box_top, box_width, box_height,
        output ready
    );
endinterface

interface yab_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [yab_pkg::CFG_IDX_W-1:0]    index;
    logic [yab_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/yab_cfg.sv
// ----------------------------------------------------------------------------
// yab_cfg
// Register file for thresholds, output scale, class count and whitelist.
// ----------------------------------------------------------------------------
module yab_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    yab_cfg_if.sink        i_cfg,
    output yab_pkg::t_cfg  o_cfg
);
    import yab_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.obj_thr     <= OBJ_THR_RST;
            r_cfg.score_thr   <= SCORE_THR_RST;
            r_cfg.scale_x     <= SCALE_RST;
            r_cfg.scale_y     <= SCALE_RST;
            r_cfg.class_count <= CLASS_COUNT_RST;
            r_cfg.filter_en   <= 1'b0;
            r_cfg.allow_lo    <= '0;
            r_cfg.allow_hi    <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_OBJ_THR:     r_cfg.obj_thr     <= i_cfg.data[16:0];
                REG_SCORE_THR:   r_cfg.score_thr   <= i_cfg.data[16:0];
                REG_SCALE_X:     r_cfg.scale_x     <= i_cfg.data[15:0];
                REG_SCALE_Y:     r_cfg.scale_y     <= i_cfg.data[15:0];
                REG_CLASS_COUNT: r_cfg.class_count <= i_cfg.data[7:0];
                REG_FILTER_EN:   r_cfg.filter_en   <= i_cfg.data[0];
                REG_ALLOW_LO:    r_cfg.allow_lo    <= i_cfg.data;
                REG_ALLOW_HI:    r_cfg.allow_hi    <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

### rtl/yab_front.sv
// ----------------------------------------------------------------------------
// yab_front
// Accept candidates, compute objectness and score, drop those that fail.
// ----------------------------------------------------------------------------
module yab_front #(
    parameter int MAX_CLASSES   = yab_pkg::MAX_CLASSES_DEF,
    parameter int GRID_ROWS_MAX = yab_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS_MAX = yab_pkg::GRID_COLS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    yab_cand_if.sink       i_cand,
    input  yab_pkg::t_cfg  i_cfg,
    input  logic           i_full,
    output logic           o_push,
    output yab_pkg::t_job  o_job
);
    import yab_pkg::*;

    logic        fe;
    logic        f2_want;
    logic        early_ok;
    logic [63:0] allow_sel;
    t_job        in_job;
    t_job        n_f2_job;
    logic [16:0] n_score;

    logic        r_f1_v;
    logic        r_f1_ok;
    logic [16:0] r_f1_obj;
    logic [16:0] r_f1_cs;
    t_job        r_f1_job;

    logic        r_f2_v;
    logic        r_f2_ok;
    t_job        r_f2_job;

    always_comb begin
        allow_sel = i_cand.class_index[6] ? i_cfg.allow_hi : i_cfg.allow_lo;
        early_ok  = (i_cand.scale_level <= LEVEL_MAX)
                 && (i_cand.anchor_sel <= ANCHOR_MAX)
                 && ({2'b0, i_cand.cell_x} < 9'(GRID_COLS_MAX))
                 && ({2'b0, i_cand.cell_y} < 9'(GRID_ROWS_MAX))
                 && ({1'b0, i_cand.class_index} < i_cfg.class_count)
                 && ({1'b0, i_cand.class_index} < 8'(MAX_CLASSES))
                 && (!i_cfg.filter_en || allow_sel[i_cand.class_index[5:0]]);

        in_job.level  = i_cand.scale_level;
        in_job.asel   = i_cand.anchor_sel;
        in_job.cell_x = i_cand.cell_x;
        in_job.cell_y = i_cand.cell_y;
        in_job.raw_x  = i_cand.raw_x;
        in_job.raw_y  = i_cand.raw_y;
        in_job.raw_w  = i_cand.raw_w;
        in_job.raw_h  = i_cand.raw_h;
        in_job.cls    = i_cand.class_index;
        in_job.score  = '0;

        n_score        = 17'((34'(r_f1_obj) * 34'(r_f1_cs)) >> 16);
        n_f2_job       = r_f1_job;
        n_f2_job.score = n_score;
    end

    assign f2_want      = r_f2_v && r_f2_ok && (r_f2_job.score >= i_cfg.score_thr);
    assign fe           = !(f2_want && i_full);
    assign i_cand.ready = fe;
    assign o_push       = f2_want && !i_full;
    assign o_job        = r_f2_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (fe) begin
            r_f1_v <= i_cand.valid;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_f1_ok  <= early_ok;
            r_f1_obj <= sig_q16(i_cand.raw_obj);
            r_f1_cs  <= sig_q16(i_cand.raw_class);
            r_f1_job <= in_job;
            r_f2_ok  <= r_f1_ok && (r_f1_obj >= i_cfg.obj_thr);
            r_f2_job <= n_f2_job;
        end
    end

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cand.ready |-> i_full)
        else $error("front stalled without a full queue");

    a_f2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f2_v && !fe) |=> (r_f2_v && $stable(r_f2_job.score)))
        else $error("front held request lost");

endmodule

### rtl/yab_queue.sv
// ----------------------------------------------------------------------------
// yab_queue
// Short FIFO of kept candidates between the front and the back pipeline.
// ----------------------------------------------------------------------------
module yab_queue #(
    parameter int DEPTH = yab_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  yab_pkg::t_job  i_job,
    input  logic           i_pop,
    output yab_pkg::t_job  o_job,
    output logic           o_full,
    output logic           o_empty
);
    import yab_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

### rtl/yab_back.sv
// ----------------------------------------------------------------------------
// yab_back
// Six-stage box geometry pipeline: sigmoids, squares, anchors, scaling, clamp.
// ----------------------------------------------------------------------------
module yab_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  yab_pkg::t_job  i_job,
    input  logic           i_empty,
    output logic           o_pop,
    input  yab_pkg::t_cfg  i_cfg,
    yab_box_if.source      o_box
);
    import yab_pkg::*;

    localparam int LANES     = 4;
    localparam int LANE_LEFT = 0;
    localparam int LANE_TOP  = 1;
    localparam int LANE_W    = 2;
    localparam int LANE_H    = 3;

    logic be;

    // stage 1
    logic        r_b1_v;
    logic [1:0]  r_b1_level;
    logic [1:0]  r_b1_asel;
    logic [6:0]  r_b1_cx;
    logic [6:0]  r_b1_cy;
    logic [6:0]  r_b1_cls;
    logic [16:0] r_b1_score;
    logic [16:0] r_b1_sx;
    logic [16:0] r_b1_sy;
    logic [16:0] r_b1_sw;
    logic [16:0] r_b1_sh;

    // stage 2
    logic               r_b2_v;
    logic [1:0]         r_b2_level;
    logic [1:0]         r_b2_asel;
    logic [6:0]         r_b2_cls;
    logic [16:0]        r_b2_score;
    logic signed [24:0] r_b2_tx;
    logic signed [24:0] r_b2_ty;
    logic [31:0]        r_b2_sw2;
    logic [31:0]        r_b2_sh2;

    // stage 3
    logic               r_b3_v;
    logic [1:0]         r_b3_level;
    logic [6:0]         r_b3_cls;
    logic [16:0]        r_b3_score;
    logic signed [24:0] r_b3_tx;
    logic signed [24:0] r_b3_ty;
    logic [40:0]        r_b3_anw;
    logic [40:0]        r_b3_anh;

    // stage 4
    logic               r_b4_v;
    logic [6:0]         r_b4_cls;
    logic [16:0]        r_b4_score;
    logic signed [46:0] r_b4_vl [LANES];

    // stage 5
    logic               r_b5_v;
    logic [6:0]         r_b5_cls;
    logic [16:0]        r_b5_score;
    logic [39:0]        r_b5_pl [LANES];
    logic signed [39:0] r_b5_ph [LANES];

    // stage 6 (output)
    logic        r_b6_v;
    logic [6:0]  r_b6_cls;
    logic [16:0] r_b6_score;
    logic [15:0] r_b6_box [LANES];

    logic signed [24:0] n_tx;
    logic signed [24:0] n_ty;
    logic [5:0]         shamt;
    logic signed [46:0] n_vl  [LANES];
    logic [15:0]        lane_scale [LANES];
    logic [39:0]        n_pl  [LANES];
    logic signed [39:0] n_ph  [LANES];
    logic signed [63:0] sum   [LANES];
    logic signed [19:0] quot  [LANES];
    logic [15:0]        n_box [LANES];

    function automatic logic [15:0] sat16(input logic signed [19:0] q,
                                          input logic floor_zero);
        logic signed [19:0] lo;
        lo = floor_zero ? 20'sd0 : -20'sd32768;
        if (q > 20'sd32767) begin
            return 16'h7FFF;
        end else if (q < lo) begin
            return 16'(lo);
        end else begin
            return 16'(q);
        end
    endfunction

    assign be    = !r_b6_v || o_box.ready;
    assign o_pop = be && !i_empty;

    always_comb begin
        n_tx  = 25'({r_b1_cx, 16'b0}) + 25'({r_b1_sx, 1'b0}) - 25'sd32768;
        n_ty  = 25'({r_b1_cy, 16'b0}) + 25'({r_b1_sy, 1'b0}) - 25'sd32768;
        shamt = 6'(STRIDE_SHIFT_BASE) + 6'(r_b3_level);

        n_vl[LANE_LEFT] = (47'(r_b3_tx) <<< shamt) - 47'({r_b3_anw, 1'b0});
        n_vl[LANE_TOP]  = (47'(r_b3_ty) <<< shamt) - 47'({r_b3_anh, 1'b0});
        n_vl[LANE_W]    = 47'({r_b3_anw, 2'b0});
        n_vl[LANE_H]    = 47'({r_b3_anh, 2'b0});

        for (int k = 0; k < LANES; k++) begin
            lane_scale[k] = (k == LANE_TOP || k == LANE_H) ? i_cfg.scale_y : i_cfg.scale_x;
            n_pl[k] = 40'(r_b4_vl[k][23:0]) * 40'(lane_scale[k]);
            n_ph[k] = 40'($signed(r_b4_vl[k][46:24])) * 40'($signed({1'b0, lane_scale[k]}));
            sum[k]  = (64'(r_b5_ph[k]) <<< 24) + 64'(r_b5_pl[k]);
            quot[k] = 20'(sum[k] >>> 44) + 20'(sum[k][63] && (|sum[k][43:0]));
            n_box[k] = sat16(quot[k], (k == LANE_W || k == LANE_H));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
            r_b4_v <= 1'b0;
            r_b5_v <= 1'b0;
            r_b6_v <= 1'b0;
        end else if (be) begin
            r_b1_v <= !i_empty;
            r_b2_v <= r_b1_v;
            r_b3_v <= r_b2_v;
            r_b4_v <= r_b3_v;
            r_b5_v <= r_b4_v;
            r_b6_v <= r_b5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (be) begin
            r_b1_level <= i_job.level;
            r_b1_asel  <= i_job.asel;
            r_b1_cx    <= i_job.cell_x;
            r_b1_cy    <= i_job.cell_y;
            r_b1_cls   <= i_job.cls;
            r_b1_score <= i_job.score;
            r_b1_sx    <= sig_q16(i_job.raw_x);
            r_b1_sy    <= sig_q16(i_job.raw_y);
            r_b1_sw    <= sig_q16(i_job.raw_w);
            r_b1_sh    <= sig_q16(i_job.raw_h);

            r_b2_level <= r_b1_level;
            r_b2_asel  <= r_b1_asel;
            r_b2_cls   <= r_b1_cls;
            r_b2_score <= r_b1_score;
            r_b2_tx    <= n_tx;
            r_b2_ty    <= n_ty;
            r_b2_sw2   <= 32'(r_b1_sw[15:0]) * 32'(r_b1_sw[15:0]);
            r_b2_sh2   <= 32'(r_b1_sh[15:0]) * 32'(r_b1_sh[15:0]);

            r_b3_level <= r_b2_level;
            r_b3_cls   <= r_b2_cls;
            r_b3_score <= r_b2_score;
            r_b3_tx    <= r_b2_tx;
            r_b3_ty    <= r_b2_ty;
            r_b3_anw   <= 41'(r_b2_sw2) * 41'(ANCHOR_W[r_b2_level][r_b2_asel]);
            r_b3_anh   <= 41'(r_b2_sh2) * 41'(ANCHOR_H[r_b2_level][r_b2_asel]);

            r_b4_cls   <= r_b3_cls;
            r_b4_score <= r_b3_score;
            r_b5_cls   <= r_b4_cls;
            r_b5_score <= r_b4_score;
            r_b6_cls   <= r_b5_cls;
            r_b6_score <= r_b5_score;
            for (int k = 0; k < LANES; k++) begin
                r_b4_vl[k]  <= n_vl[k];
                r_b5_pl[k]  <= n_pl[k];
                r_b5_ph[k]  <= n_ph[k];
                r_b6_box[k] <= n_box[k];
            end
        end
    end

    assign o_box.valid      = r_b6_v;
    assign o_box.out_class  = r_b6_cls;
    assign o_box.out_score  = r_b6_score;
    assign o_box.box_left   = r_b6_box[LANE_LEFT];
    assign o_box.box_top    = r_b6_box[LANE_TOP];
    assign o_box.box_width  = r_b6_box[LANE_W][14:0];
    assign o_box.box_height = r_b6_box[LANE_H][14:0];

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !be |=> $stable({r_b1_v, r_b2_v, r_b3_v, r_b4_v, r_b5_v}))
        else $error("back pipeline moved while stalled");

endmodule

### rtl/yolo_anchor_box_decode.sv
// ----------------------------------------------------------------------------
// yolo_anchor_box_decode
// Decodes one anchor candidate per request into a scaled, saturated box.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake   | content
//  ---------+-----+-------------+-----------------------------------------------
//  i_cand   | in  | valid/ready | level, anchor, cell, box/obj/class logits
//  o_box    | out | valid/ready | class, score, left, top, width, height
//  i_cfg    | in  | valid/ready | register index and write data, always ready
//
//  One candidate per cycle sustained while o_box is ready; every stage is fully pipelined.
//  Path: filter front registers F1 and F2, then the queue, then the
//  geometry pipeline (multiplier chain square, anchor, split scale product).
//  Reset returns the configuration registers to their defaults and empties every stage.
//  Output stall freezes the geometry pipeline; the front keeps taking
//  candidates until the queue fills, then drops ready.
// ----------------------------------------------------------------------------
module yolo_anchor_box_decode #(
    parameter int MAX_CLASSES   = yab_pkg::MAX_CLASSES_DEF,
    parameter int GRID_ROWS_MAX = yab_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS_MAX = yab_pkg::GRID_COLS_DEF,
    parameter int QUEUE_DEPTH   = yab_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    yab_cand_if.sink    i_cand,
    yab_box_if.source   o_box,
    yab_cfg_if.sink     i_cfg
);
    import yab_pkg::*;

    t_cfg cfg;
    t_job push_job;
    t_job pop_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    yab_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    yab_front #(
        .MAX_CLASSES   (MAX_CLASSES),
        .GRID_ROWS_MAX (GRID_ROWS_MAX),
        .GRID_COLS_MAX (GRID_COLS_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (i_cand),
        .i_cfg   (cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    yab_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_full  (full),
        .o_empty (empty)
    );

    yab_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (pop_job),
        .i_empty (empty),
        .o_pop   (pop),
        .i_cfg   (cfg),
        .o_box   (o_box)
    );

endmodule

### tb/yab_box_checker.sv
// ----------------------------------------------------------------------------
// yab_box_checker
// Watches the register, candidate and box channels of the anchor box decoder.
// Keeps its own copy of the registers, predicts the box that each accepted
// candidate must give (if any), and compares every box, field by field,
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module yab_box_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    yab_cand_if  i_cand,
    yab_box_if   i_box,
    yab_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_boxes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0]  cls;
        logic [16:0] score;
        logic [15:0] left;
        logic [15:0] top;
        logic [14:0] width;
        logic [14:0] height;
    } t_box;

    localparam int SIGMOID_PTS [0:16] = '{
        32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
        64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
    };

    localparam int ANCHOR_PX_W [0:2][0:2] = '{
        '{12, 19, 40}, '{36, 76, 72}, '{142, 192, 459}
    };
    localparam int ANCHOR_PX_H [0:2][0:2] = '{
        '{16, 36, 28}, '{75, 55, 146}, '{110, 243, 401}
    };

    yab_pkg::t_cfg regs;
    t_box          boxes_due [$];
    int            fail_count    = 0;
    int            boxes_checked = 0;
    int            due_count     = 0;

    assign o_fail_count    = fail_count;
    assign o_pending       = due_count;
    assign o_boxes_checked = boxes_checked;

    // Q8.8 logit to Q0.16 probability
    function automatic int logistic_q16(input logic [15:0] raw);
        int x;
        int mag;
        int idx;
        int y;
        x   = int'($signed(raw));
        mag = (x < 0) ? -x : x;
        if (mag >= 2048) begin
            y = SIGMOID_PTS[16];
        end else begin
            idx = mag >> 7;
            y   = SIGMOID_PTS[idx]
                + (((SIGMOID_PTS[idx + 1] - SIGMOID_PTS[idx]) * (mag & 127)) >> 7);
        end
        return (x < 0) ? 65536 - y : y;
    endfunction

    function automatic longint scale_q44(input longint v, input logic [15:0] s);
        return (v * longint'(s)) / (longint'(1) << 44);
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic bit decode_box(
        input  yab_pkg::t_cfg c,
        input  logic [1:0]    lvl,
        input  logic [1:0]    anc,
        input  logic [6:0]    cx,
        input  logic [6:0]    cy,
        input  logic [15:0]   rx,
        input  logic [15:0]   ry,
        input  logic [15:0]   rw,
        input  logic [15:0]   rh,
        input  logic [15:0]   robj,
        input  logic [6:0]    cls,
        input  logic [15:0]   rcls,
        output t_box          b
    );
        logic [63:0] mask;
        longint      obj;
        longint      prob;
        longint      score;
        longint      stride;
        longint      tx;
        longint      ty;
        longint      sw2;
        longint      sh2;
        longint      w32;
        longint      h32;
        b = '0;
        if (lvl > yab_pkg::LEVEL_MAX || anc > yab_pkg::ANCHOR_MAX) return 1'b0;
        if (int'(cx) >= yab_pkg::GRID_COLS_DEF || int'(cy) >= yab_pkg::GRID_ROWS_DEF) begin
            return 1'b0;
        end
        if (int'(cls) >= int'(c.class_count) || int'(cls) >= yab_pkg::MAX_CLASSES_DEF) begin
            return 1'b0;
        end
        if (c.filter_en) begin
            mask = cls[6] ? c.allow_hi : c.allow_lo;
            if (!mask[cls[5:0]]) return 1'b0;
        end
        obj = longint'(logistic_q16(robj));
        if (obj < longint'(c.obj_thr)) return 1'b0;
        prob  = longint'(logistic_q16(rcls));
        score = (obj * prob) / 65536;
        if (score < longint'(c.score_thr)) return 1'b0;

        stride = longint'(8) << lvl;
        tx  = 2 * longint'(logistic_q16(rx)) - 32768 + longint'(cx) * 65536;
        ty  = 2 * longint'(logistic_q16(ry)) - 32768 + longint'(cy) * 65536;
        sw2 = 2 * longint'(logistic_q16(rw));
        sh2 = 2 * longint'(logistic_q16(rh));
        w32 = sw2 * sw2 * longint'(ANCHOR_PX_W[lvl][anc]);
        h32 = sh2 * sh2 * longint'(ANCHOR_PX_H[lvl][anc]);

        b.cls    = cls;
        b.score  = 17'(score);
        b.left   = 16'(clip(scale_q44(tx * stride * 65536 - w32 / 2, c.scale_x), -32768, 32767));
        b.top    = 16'(clip(scale_q44(ty * stride * 65536 - h32 / 2, c.scale_y), -32768, 32767));
        b.width  = 15'(clip(scale_q44(w32, c.scale_x), 0, 32767));
        b.height = 15'(clip(scale_q44(h32, c.scale_y), 0, 32767));
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [7:0] idx, input logic [63:0] data);
        case (idx)
            yab_pkg::REG_OBJ_THR:     regs.obj_thr     = data[16:0];
            yab_pkg::REG_SCORE_THR:   regs.score_thr   = data[16:0];
            yab_pkg::REG_SCALE_X:     regs.scale_x     = data[15:0];
            yab_pkg::REG_SCALE_Y:     regs.scale_y     = data[15:0];
            yab_pkg::REG_CLASS_COUNT: regs.class_count = data[7:0];
            yab_pkg::REG_FILTER_EN:   regs.filter_en   = data[0];
            yab_pkg::REG_ALLOW_LO:    regs.allow_lo    = data;
            yab_pkg::REG_ALLOW_HI:    regs.allow_hi    = data;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_count < 40) $display("checker: %s: got %0d, expected %0d", what, got, want);
        fail_count++;
    endtask

    task automatic compare_box(input t_box got, input t_box want);
        if (got.cls !== want.cls) report_mismatch("out_class", got.cls, want.cls);
        if (got.score !== want.score) report_mismatch("out_score", got.score, want.score);
        if (got.left !== want.left) begin
            report_mismatch("box_left", $signed(got.left), $signed(want.left));
        end
        if (got.top !== want.top) report_mismatch("box_top", $signed(got.top), $signed(want.top));
        if (got.width !== want.width) report_mismatch("box_width", got.width, want.width);
        if (got.height !== want.height) report_mismatch("box_height", got.height, want.height);
    endtask

    always @(posedge i_clk) begin
        t_box got;
        t_box want;
        t_box fresh;
        if (!i_rst_n) begin
            regs.obj_thr     = yab_pkg::OBJ_THR_RST;
            regs.score_thr   = yab_pkg::SCORE_THR_RST;
            regs.scale_x     = yab_pkg::SCALE_RST;
            regs.scale_y     = yab_pkg::SCALE_RST;
            regs.class_count = yab_pkg::CLASS_COUNT_RST;
            regs.filter_en   = 1'b0;
            regs.allow_lo    = '0;
            regs.allow_hi    = '0;
            boxes_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) write_reg(i_cfg.index, i_cfg.data);
            if (i_box.valid && i_box.ready) begin
                got.cls    = i_box.out_class;
                got.score  = i_box.out_score;
                got.left   = i_box.box_left;
                got.top    = i_box.box_top;
                got.width  = i_box.box_width;
                got.height = i_box.box_height;
                if (boxes_due.size() == 0) begin
                    report_mismatch("box with no candidate pending, out_class", got.cls, -1);
                end else begin
                    want = boxes_due.pop_front();
                    compare_box(got, want);
                    boxes_checked++;
                end
            end
            if (i_cand.valid && i_cand.ready) begin
                if (decode_box(regs, i_cand.scale_level, i_cand.anchor_sel, i_cand.cell_x,
                               i_cand.cell_y, i_cand.raw_x, i_cand.raw_y, i_cand.raw_w,
                               i_cand.raw_h, i_cand.raw_obj, i_cand.class_index,
                               i_cand.raw_class, fresh)) begin
                    boxes_due.insert(boxes_due.size(), fresh);
                end
            end
        end
        due_count = boxes_due.size();
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives candidates and register writes into the anchor box decoder through
// twelve register settings (reset values, pass-all, drop-all, saturating and
// zero scales, whitelists full, empty and random, random mixes) under three
// idling patterns, and reports the verdict from the box checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT       = 4000;
    localparam int PHASES           = 12;
    localparam int ITEMS_PER_PHASE  = 185;
    localparam int ITEMS_DROP_PHASE = 40;
    localparam int SETTLE_CYCLES    = 16;

    localparam logic [7:0] REG_UNUSED_FIRST = 8'd8;
    localparam logic [7:0] REG_UNUSED_LAST  = 8'hFF;
    localparam logic [1:0] LEVEL_RESERVED   = 2'd3;
    localparam logic [1:0] ANCHOR_RESERVED  = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int class_limit  = 80;
    int cands_sent   = 0;
    int quiet_cycles = 0;
    int fail_count;
    int due_count;
    int boxes_checked;

    yab_cand_if cand_ch ();
    yab_box_if  box_ch ();
    yab_cfg_if  cfg_ch ();

    yolo_anchor_box_decode dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cand  (cand_ch),
        .o_box   (box_ch),
        .i_cfg   (cfg_ch)
    );

    yab_box_checker u_chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cand          (cand_ch),
        .i_box           (box_ch),
        .i_cfg           (cfg_ch),
        .o_fail_count    (fail_count),
        .o_pending       (due_count),
        .o_boxes_checked (boxes_checked)
    );

    always #4 clk = ~clk;

    always @(negedge clk) begin
        box_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((cand_ch.valid && cand_ch.ready) || (box_ch.valid && box_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_cand(
        input logic [1:0]  lvl,
        input logic [1:0]  anc,
        input logic [6:0]  cx,
        input logic [6:0]  cy,
        input logic [15:0] rx,
        input logic [15:0] ry,
        input logic [15:0] rw,
        input logic [15:0] rh,
        input logic [15:0] robj,
        input logic [6:0]  cls,
        input logic [15:0] rcls
    );
        while ($urandom_range(99) < tx_idle_pct) begin
            cand_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cand_ch.valid       <= 1'b1;
        cand_ch.scale_level <= lvl;
        cand_ch.anchor_sel  <= anc;
        cand_ch.cell_x      <= cx;
        cand_ch.cell_y      <= cy;
        cand_ch.raw_x       <= rx;
        cand_ch.raw_y       <= ry;
        cand_ch.raw_w       <= rw;
        cand_ch.raw_h       <= rh;
        cand_ch.raw_obj     <= robj;
        cand_ch.class_index <= cls;
        cand_ch.raw_class   <= rcls;
        do @(posedge clk); while (!cand_ch.ready);
        cands_sent++;
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_logit();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 16'(int'($urandom_range(5120)) - 2560);
        if (r < 85) return 16'($urandom);
        case ($urandom_range(5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0800;
            3:       return 16'hF800;
            4:       return 16'h07FF;
            default: return 16'h0000;
        endcase
    endfunction

    task automatic send_random_cand();
        logic [1:0] lvl;
        logic [1:0] anc;
        logic [6:0] cls;
        lvl = ($urandom_range(9) == 0) ? LEVEL_RESERVED : 2'($urandom_range(2));
        anc = ($urandom_range(9) == 0) ? ANCHOR_RESERVED : 2'($urandom_range(2));
        cls = ($urandom_range(99) < 85) ? 7'($urandom_range(class_limit - 1)) : 7'($urandom);
        send_cand(lvl, anc, 7'($urandom), 7'($urandom), pick_logit(), pick_logit(),
                  pick_logit(), pick_logit(), pick_logit(), cls, pick_logit());
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [63:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    // upper bits beyond each register's width carry noise and must be dropped
    task automatic set_regs(
        input logic [16:0] obj_thr,
        input logic [16:0] score_thr,
        input logic [15:0] sx,
        input logic [15:0] sy,
        input int          cc,
        input logic        fen,
        input logic [63:0] lo,
        input logic [63:0] hi
    );
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_write(yab_pkg::REG_OBJ_THR, {junk[63:17], obj_thr});
        cfg_write(yab_pkg::REG_SCORE_THR, {junk[63:17], score_thr});
        cfg_write(yab_pkg::REG_SCALE_X, {junk[63:16], sx});
        cfg_write(yab_pkg::REG_SCALE_Y, {junk[63:16], sy});
        cfg_write(yab_pkg::REG_CLASS_COUNT, {junk[63:8], 8'(cc)});
        cfg_write(yab_pkg::REG_FILTER_EN, {junk[63:1], fen});
        cfg_write(yab_pkg::REG_ALLOW_LO, lo);
        cfg_write(yab_pkg::REG_ALLOW_HI, hi);
        cfg_ch.valid <= 1'b0;
        class_limit = cc;
    endtask

    initial begin
        int p;
        int n;
        cand_ch.valid       = 1'b0;
        cand_ch.scale_level = '0;
        cand_ch.anchor_sel  = '0;
        cand_ch.cell_x      = '0;
        cand_ch.cell_y      = '0;
        cand_ch.raw_x       = '0;
        cand_ch.raw_y       = '0;
        cand_ch.raw_w       = '0;
        cand_ch.raw_h       = '0;
        cand_ch.raw_obj     = '0;
        cand_ch.class_index = '0;
        cand_ch.raw_class   = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        box_ch.ready        = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (p = 0; p < PHASES; p++) begin
            tx_idle_pct  = (p < 4) ? 6 : ((p < 8) ? 84 : 0);
            rx_stall_pct = (p < 4) ? 84 : ((p < 8) ? 6 : 0);
            n = ITEMS_PER_PHASE;
            case (p)
                0: begin
                    // reset values: field extremes, table ends, every drop reason but the whitelist
                    send_cand(2'd0, 2'd0, 7'd0, 7'd0, 16'h8000, 16'h8000, 16'h8000,
                              16'h8000, 16'h7FFF, 7'd0, 16'h7FFF);
                    send_cand(2'd2, 2'd2, 7'd127, 7'd127, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                              16'h7FFF, 16'h7FFF, 7'd79, 16'h7FFF);
                    send_cand(2'd1, 2'd1, 7'd64, 7'd3, 16'h0800, 16'hF800, 16'h0800,
                              16'hF800, 16'h0800, 7'd5, 16'h0800);
                    send_cand(2'd1, 2'd2, 7'd10, 7'd20, 16'h07FF, 16'hF801, 16'h0080,
                              16'hFF7F, 16'h07FF, 7'd17, 16'h0400);
                    send_cand(LEVEL_RESERVED, 2'd0, 7'd1, 7'd1, 16'h0000, 16'h0000,
                              16'h0000, 16'h0000, 16'h7FFF, 7'd2, 16'h7FFF);
                    send_cand(2'd0, ANCHOR_RESERVED, 7'd1, 7'd1, 16'h0000, 16'h0000,
                              16'h0000, 16'h0000, 16'h7FFF, 7'd2, 16'h7FFF);
                    send_cand(2'd0, 2'd1, 7'd5, 7'd5, 16'h0000, 16'h0000, 16'h0000,
                              16'h0000, 16'h7FFF, 7'd80, 16'h7FFF);
                    send_cand(2'd0, 2'd1, 7'd5, 7'd5, 16'h0000, 16'h0000, 16'h0000,
                              16'h0000, 16'h7FFF, 7'd127, 16'h7FFF);
                    send_cand(2'd1, 2'd0, 7'd9, 7'd9, 16'h0100, 16'h0100, 16'h0100,
                              16'h0100, 16'h8000, 7'd3, 16'h7FFF);
                    send_cand(2'd1, 2'd0, 7'd9, 7'd9, 16'h0100, 16'h0100, 16'h0100,
                              16'h0100, 16'h0000, 7'd3, 16'h0000);
                    send_cand(2'd1, 2'd0, 7'd9, 7'd9, 16'h0100, 16'h0100, 16'h0100,
                              16'h0100, 16'h0000, 7'd3, 16'h7FFF);
                    send_cand(2'd2, 2'd0, 7'd0, 7'd127, 16'h8000, 16'h7FFF, 16'h0001,
                              16'hFFFF, 16'hFE00, 7'd1, 16'h7FFF);
                    send_cand(2'd2, 2'd1, 7'd127, 7'd0, 16'h0001, 16'hFFFF, 16'h8000,
                              16'h7FFF, 16'h0100, 7'd42, 16'h0100);
                end
                1: begin
                    set_regs(17'd8192, 17'd12000, 16'd2048, 16'd6000, 100, 1'b0,
                             64'd0, 64'd0);
                    @(negedge clk);
                    cfg_write(REG_UNUSED_FIRST, {$urandom, $urandom});
                    cfg_write(REG_UNUSED_LAST, {$urandom, $urandom});
                    cfg_ch.valid <= 1'b0;
                end
                2: set_regs(17'd0, 17'd0, 16'hFFFF, 16'hFFFF, 128, 1'b0,
                            {$urandom, $urandom}, {$urandom, $urandom});
                3: begin
                    set_regs(17'd65536, 17'd65536, 16'($urandom), 16'($urandom), 128,
                             1'b0, 64'd0, 64'd0);
                    n = ITEMS_DROP_PHASE;
                end
                4: set_regs(17'($urandom_range(30000)), 17'($urandom_range(30000)),
                            16'($urandom), 16'($urandom), 128, 1'b1,
                            {$urandom, $urandom}, {$urandom, $urandom});
                5: begin
                    set_regs(17'd0, 17'd0, 16'd4096, 16'd4096, 128, 1'b1, 64'd0, 64'd0);
                    n = ITEMS_DROP_PHASE;
                end
                6: set_regs(17'd0, 17'd0, 16'd0, 16'd0, 1, 1'b0, 64'd0, 64'd0);
                7: set_regs(17'd16384, 17'd0, 16'd4096, 16'd4096, 100, 1'b1, '1, '1);
                default: set_regs(17'($urandom_range(40000)), 17'($urandom_range(40000)),
                                  16'($urandom_range(512, 12288)),
                                  16'($urandom_range(512, 12288)),
                                  $urandom_range(1, 128), 1'($urandom_range(1)),
                                  {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            repeat (n) send_random_cand();
            cand_ch.valid <= 1'b0;
            while (due_count != 0) @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end

        $display("summary: %0d candidates over %0d register settings, %0d boxes compared",
                 cands_sent, PHASES, boxes_checked);
        $display("summary: idling on either side and none; thresholds, scales, class %s",
                 "count and whitelist taken to their extremes");
        if (fail_count == 0 && due_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
